>>> rtl/sfh_pkg.sv
// ----------------------------------------------------------------------------
// sfh_pkg
// Shared types, constants and mixing functions for the streaming
// SuperFastHash block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfh_pkg;

  // Width of the length counter and the stated length
  localparam int LEN_BITS  = 16;
  // Width of the total_length input field
  localparam int TLEN_W    = 16;
  localparam int WORD_W    = 32;
  localparam int NBYTES_W  = 3;
  localparam logic [NBYTES_W-1:0] FULL_WORD = 3'd4;

  // One finished message handed from the front end to the back end
  typedef struct packed {
    logic [WORD_W-1:0] hash;      // hash before the final avalanche
    logic              zero_len;  // stated length was zero
    logic              mismatch;  // counted bytes differ from stated length
  } sfh_entry_t;

  // Sign-extend one byte to a full word
  function automatic logic [WORD_W-1:0] sext8(input logic [7:0] b);
    sext8 = {{(WORD_W-8){b[7]}}, b};
  endfunction

  // Full-word mix as two 16-bit halves
  function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] h_in,
                                                 input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] h;
    logic [WORD_W-1:0] t;
    h = h_in + {16'h0, w[15:0]};
    t = ({16'h0, w[31:16]} << 11) ^ h;
    h = (h << 16) ^ t;
    h = h + (h >> 11);
    mix_word = h;
  endfunction

  // Tail mix for a remainder of one, two or three bytes
  function automatic logic [WORD_W-1:0] mix_tail(input logic [WORD_W-1:0] h_in,
                                                 input logic [WORD_W-1:0] w,
                                                 input logic [NBYTES_W-1:0] n);
    logic [WORD_W-1:0] h;
    h = h_in;
    case (n)
      3'd3: begin
        h = h + {16'h0, w[15:0]};
        h = h ^ (h << 16);
        h = h ^ (sext8(w[23:16]) << 18);
        h = h + (h >> 11);
      end
      3'd2: begin
        h = h + {16'h0, w[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      3'd1: begin
        h = h + sext8(w[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: h = h_in;
    endcase
    mix_tail = h;
  endfunction

  // Final avalanche
  function automatic logic [WORD_W-1:0] avalanche(input logic [WORD_W-1:0] h_in);
    logic [WORD_W-1:0] h;
    h = h_in;
    h = h ^ (h << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    h = h + (h >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    avalanche = h;
  endfunction

endpackage

`default_nettype wire

>>> rtl/sfh_front.sv
// ----------------------------------------------------------------------------
// sfh_front
// Accepts message words, keeps the running hash and byte count, and on the
// last word pushes the pre-avalanche hash and length flags to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sfh_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sfh_pkg::WORD_W-1:0]    in_word,
  input  wire logic [sfh_pkg::NBYTES_W-1:0]  in_valid_bytes,
  input  wire logic                          in_last,
  input  wire logic [sfh_pkg::TLEN_W-1:0]    in_total_length,
  input  wire logic                          q_full,
  output logic                               q_push,
  output sfh_pkg::sfh_entry_t                q_entry
);
  import sfh_pkg::*;

  logic                 in_msg_r,  in_msg_nxt;
  logic [WORD_W-1:0]    hash_r,    hash_nxt;
  logic [LEN_BITS-1:0]  count_r,   count_nxt;
  logic [LEN_BITS-1:0]  stated_r,  stated_nxt;

  logic                 accept;
  logic [NBYTES_W-1:0]  n_clamp;
  logic [WORD_W-1:0]    hash_base;
  logic [LEN_BITS-1:0]  count_base;
  logic [LEN_BITS:0]    count_sum;
  logic [LEN_BITS-1:0]  count_new;
  logic [WORD_W-1:0]    hash_full;
  logic [WORD_W-1:0]    hash_last;

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;

  // Clamp valid byte count to a full word
  assign n_clamp = (in_valid_bytes > FULL_WORD) ? FULL_WORD : in_valid_bytes;

  // First word of a message seeds hash and length
  always_comb begin
    if (in_msg_r) begin
      stated_nxt = stated_r;
      hash_base  = hash_r;
      count_base = count_r;
    end else begin
      stated_nxt = LEN_BITS'(in_total_length);
      hash_base  = WORD_W'(LEN_BITS'(in_total_length));
      count_base = '0;
    end
  end

  // Saturating byte count
  assign count_sum = {1'b0, count_base} + (LEN_BITS+1)'(n_clamp);
  assign count_new = count_sum[LEN_BITS] ? {LEN_BITS{1'b1}} : count_sum[LEN_BITS-1:0];

  // Mix paths
  assign hash_full = mix_word(hash_base, in_word);
  assign hash_last = (n_clamp == FULL_WORD) ? hash_full : mix_tail(hash_base, in_word, n_clamp);

  assign in_msg_nxt = ~in_last;
  assign hash_nxt   = hash_full;
  assign count_nxt  = count_new;

  // Queue push on the last word
  assign q_push           = accept & in_last;
  assign q_entry.hash     = hash_last;
  assign q_entry.zero_len = (stated_nxt == '0);
  assign q_entry.mismatch = (count_new != stated_nxt);

  // Message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
    end else if (accept) begin
      in_msg_r <= in_msg_nxt;
    end
  end

  // Running values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r   <= '0;
      count_r  <= '0;
      stated_r <= '0;
    end else if (accept) begin
      hash_r   <= hash_nxt;
      count_r  <= count_nxt;
      stated_r <= stated_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sfh_queue.sv
// ----------------------------------------------------------------------------
// sfh_queue
// Two-entry queue of finished messages between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sfh_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire sfh_pkg::sfh_entry_t push_entry,
  output logic                     full,
  input  wire logic                pop,
  output logic                     q_valid,
  output sfh_pkg::sfh_entry_t      head
);
  import sfh_pkg::*;

  sfh_entry_t  slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r,    cnt_nxt;
  logic        do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign head    = slot_r[rd_ptr_r];

  assign do_push = push & ~full;
  assign do_pop  = pop & q_valid;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sfh_back.sv
// ----------------------------------------------------------------------------
// sfh_back
// Takes finished messages from the queue, applies the final avalanche and
// holds the request in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sfh_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire sfh_pkg::sfh_entry_t         head,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [sfh_pkg::WORD_W-1:0]       out_hash_value,
  output logic                             out_length_mismatch
);
  import sfh_pkg::*;

  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] hash_r,      hash_nxt;
  logic              mis_r,       mis_nxt;

  // Load when the output register is empty or being drained
  assign pop = q_valid & (~out_valid_r | out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    hash_nxt = head.zero_len ? '0 : avalanche(head.hash);
    mis_nxt  = head.mismatch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      hash_r <= hash_nxt;
      mis_r  <= mis_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hash_value      = hash_r;
  assign out_length_mismatch = mis_r;

endmodule

`default_nettype wire

>>> rtl/superfasthash_stream_top.sv
// Throughput: one word per cycle while the queue is not full; the
// running-hash mix in the front end sets that figure, and the two-entry
// queue absorbs output stalls.
// Reset: synchronous, active low; clears message state, queue and output
// valid. No clearing pass; ready is high as soon as the queue is cleared.
// ----------------------------------------------------------------------------
// superfasthash_stream_top
// Streaming 32-bit SuperFastHash: front end mixes words, back end runs the
// final avalanche and drives the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module superfasthash_stream_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sfh_pkg::WORD_W-1:0]    in_word,
  input  wire logic [sfh_pkg::NBYTES_W-1:0]  in_valid_bytes,
  input  wire logic                          in_last,
  input  wire logic [sfh_pkg::TLEN_W-1:0]    in_total_length,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sfh_pkg::WORD_W-1:0]         out_hash_value,
  output logic                               out_length_mismatch
);
  import sfh_pkg::*;

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  sfh_entry_t q_in;
  sfh_entry_t q_head;

  sfh_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_word         (in_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_last         (in_last),
    .in_total_length (in_total_length),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (q_in)
  );

  sfh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .head       (q_head)
  );

  sfh_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .head                (q_head),
    .pop                 (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hash_value      (out_hash_value),
    .out_length_mismatch (out_length_mismatch)
  );

endmodule

`default_nettype wire

>>> rtl/sfh_checker.sv
// ----------------------------------------------------------------------------
// sfh_checker
// Port-level checks for the streaming hash block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfh_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_last,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_hash_value,
  input wire logic        out_length_mismatch
);

  // A stalled result request stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hash_value) && $stable(out_length_mismatch))
    else $error("result payload changed while stalled");

  // Input backpressure only comes from a stalled result
  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low without a pending result");

  // An accepted last word produces a result request
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> ##1 out_valid)
    else $error("no result after last word");

endmodule

bind superfasthash_stream_top sfh_checker u_sfh_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .in_last             (in_last),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_hash_value      (out_hash_value),
  .out_length_mismatch (out_length_mismatch)
);

`default_nettype wire

>>> tb/superfasthash_stream_top_tb.sv
// ----------------------------------------------------------------------------
// superfasthash_stream_top_tb
// Self-checking bench for the streaming SuperFastHash block. A queue-fed
// driver sends message words, a behavioral hash model predicts each
// message's hash and length flag, and a monitor checks every result in
// order. The run steps through idle/stall phases on both channels.
// ----------------------------------------------------------------------------
module superfasthash_stream_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfh_pkg::*;

  localparam int IDLE_LIMIT  = 5000;   // cycles without any accepted request
  localparam int PHASE_ITEMS = 140;    // random words per phase
  localparam logic [LEN_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [WORD_W-1:0]   word;
    logic [NBYTES_W-1:0] nbytes;
    logic                last;
    logic [TLEN_W-1:0]   tlen;
  } word_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] hash;
    logic              mismatch;
  } hash_result_t;

  // DUT connections; the driven inputs are known from time zero
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [WORD_W-1:0]   in_word = '0;
  logic [NBYTES_W-1:0] in_valid_bytes = '0;
  logic                in_last = 1'b0;
  logic [TLEN_W-1:0]   in_total_length = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [WORD_W-1:0]   out_hash_value;
  logic                out_length_mismatch;

  // Stimulus and scoreboard storage
  word_req_t    word_queue[$];
  hash_result_t pending_hashes[$];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           items_queued = 0;
  int           words_accepted = 0;
  int           hashes_checked = 0;
  int           errors = 0;
  int           idle_cycles = 0;

  // Hash model state
  logic [WORD_W-1:0]   acc_hash = '0;
  bit                  msg_open = 1'b0;
  logic [LEN_BITS-1:0] byte_count = '0;
  logic [LEN_BITS-1:0] len_stated = '0;

  superfasthash_stream_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_word             (in_word),
    .in_valid_bytes      (in_valid_bytes),
    .in_last             (in_last),
    .in_total_length     (in_total_length),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hash_value      (out_hash_value),
    .out_length_mismatch (out_length_mismatch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---- hash model ----------------------------------------------------------

  function automatic logic [31:0] byte_sext(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  // Full word: low half added, high half folded in at bit 11
  function automatic logic [31:0] fold_full(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] x;
    x = h + {16'h0, w[15:0]};
    x = (x << 16) ^ ({16'h0, w[31:16]} << 11) ^ x;
    return x + (x >> 11);
  endfunction

  // Remainder of 1..3 bytes; zero leaves the hash alone
  function automatic logic [31:0] fold_tail(input logic [31:0] h, input logic [31:0] w,
                                            input logic [2:0] n);
    logic [31:0] x;
    x = h;
    case (n)
      3'd3: begin
        x += {16'h0, w[15:0]};
        x ^= x << 16;
        x ^= byte_sext(w[23:16]) << 18;
        x += x >> 11;
      end
      3'd2: begin
        x += {16'h0, w[15:0]};
        x ^= x << 11;
        x += x >> 17;
      end
      3'd1: begin
        x += byte_sext(w[7:0]);
        x ^= x << 10;
        x += x >> 1;
      end
      default: x = h;
    endcase
    return x;
  endfunction

  function automatic logic [31:0] finish_hash(input logic [31:0] h);
    logic [31:0] x;
    x = h;
    x ^= x << 3;
    x += x >> 5;
    x ^= x << 4;
    x += x >> 17;
    x ^= x << 25;
    x += x >> 6;
    return x;
  endfunction

  // Advance the model by one accepted word; queue a result on the last word
  task automatic advance_hash(input word_req_t r);
    logic [NBYTES_W-1:0] n;
    hash_result_t        res;
    n = (r.nbytes > FULL_WORD) ? FULL_WORD : r.nbytes;
    if (!msg_open) begin
      len_stated = r.tlen[LEN_BITS-1:0];
      acc_hash   = WORD_W'(len_stated);
      byte_count = '0;
      msg_open   = 1'b1;
    end
    // byte count saturates instead of wrapping
    if (COUNT_MAX - byte_count < n) byte_count = COUNT_MAX;
    else byte_count += n;
    if (!r.last) begin
      acc_hash = fold_full(acc_hash, r.word);
    end else begin
      acc_hash = (n == FULL_WORD) ? fold_full(acc_hash, r.word)
                                  : fold_tail(acc_hash, r.word, n);
      res.hash     = (len_stated == 0) ? '0 : finish_hash(acc_hash);
      res.mismatch = (byte_count != len_stated);
      pending_hashes.push_back(res);
      msg_open = 1'b0;
    end
  endtask

  // ---- stimulus builders ---------------------------------------------------

  task automatic push_word(input logic [31:0] w, input logic [2:0] nb, input logic lst,
                           input logic [15:0] tl);
    word_queue.push_back(word_req_t'{w, nb, lst, tl});
    items_queued++;
  endtask

  // Well-formed framing of nbytes; length field only matters on the first word
  task automatic push_message(input int unsigned nbytes, input logic [15:0] stated,
                              input bit pad_empty);
    int unsigned full;
    int unsigned rem;
    full = nbytes / 4;
    rem  = nbytes % 4;
    if (rem == 0 && full > 0 && !pad_empty) begin
      full--;
      rem = 4;
    end
    for (int unsigned i = 0; i < full; i++)
      push_word($urandom, FULL_WORD, 1'b0, (i == 0) ? stated : 16'($urandom));
    push_word($urandom, 3'(rem), 1'b1, (full == 0) ? stated : 16'($urandom));
  endtask

  task automatic random_message();
    int unsigned pick;
    int unsigned sel;
    int unsigned len;
    int unsigned k;
    pick = $urandom_range(99);
    sel  = $urandom_range(99);
    if (sel < 70)      len = $urandom_range(16);
    else if (sel < 95) len = $urandom_range(64, 17);
    else               len = $urandom_range(256, 65);
    if (pick < 75) begin
      push_message(len, 16'(len), 1'($urandom_range(1)));
    end else if (pick < 85) begin
      // stated length off by one or anywhere in range
      push_message(len, $urandom_range(1) ? 16'($urandom) : 16'(len + 1),
                   1'($urandom_range(1)));
    end else if (pick < 93) begin
      // broken framing: short or over-range counts inside the message
      k = $urandom_range(6, 1);
      for (int unsigned i = 0; i < k; i++)
        push_word($urandom, 3'($urandom_range(7)), 1'b0, 16'($urandom));
      push_word($urandom, 3'($urandom_range(7)), 1'b1, 16'($urandom));
    end else begin
      // stray word that runs into the next message
      push_word($urandom, 3'($urandom_range(7)), 1'b0, 16'($urandom));
    end
  endtask

  // ---- input driver --------------------------------------------------------
  always @(posedge clk) begin
    word_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_hash(word_req_t'{in_word, in_valid_bytes, in_last, in_total_length});
        words_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (word_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = word_queue.pop_front();
          in_valid        <= 1'b1;
          in_word         <= nxt.word;
          in_valid_bytes  <= nxt.nbytes;
          in_last         <= nxt.last;
          in_total_length <= nxt.tlen;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- result monitor ------------------------------------------------------
  always @(posedge clk) begin
    hash_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_hashes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual hash %h flag %b",
                   $time, out_hash_value, out_length_mismatch);
        end else begin
          want = pending_hashes.pop_front();
          hashes_checked++;
          if (out_hash_value !== want.hash) begin
            errors++;
            $display("%0t: hash_value expected %h actual %h",
                     $time, want.hash, out_hash_value);
          end
          if (out_length_mismatch !== want.mismatch) begin
            errors++;
            $display("%0t: length_mismatch expected %b actual %b",
                     $time, want.mismatch, out_length_mismatch);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---- watchdog: no request moving while work is outstanding ---------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles <= 0;
      else if (word_queue.size() > 0 || in_valid || pending_hashes.size() > 0)
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog, no request accepted in %0d cycles", $time, IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---- test sequence -------------------------------------------------------
  initial begin
    int start;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase

      if (ph == 0) begin
        // empty message, and zero stated length with data present
        push_word(32'h0000_0000, 3'd0, 1'b1, 16'd0);
        push_word(32'hDEAD_BEEF, FULL_WORD, 1'b1, 16'd0);
        // lone bytes, negative and positive
        push_word(32'hFFFF_FF80, 3'd1, 1'b1, 16'd1);
        push_word(32'h0000_007F, 3'd1, 1'b1, 16'd1);
        push_word(32'hFFFF_FFFF, 3'd2, 1'b1, 16'd2);
        // three-byte tails with the odd byte negative, then positive
        push_word(32'h0080_FFFF, 3'd3, 1'b1, 16'd3);
        push_word(32'h1234_5678, 3'd3, 1'b1, 16'd3);
        push_word(32'hFFFF_FFFF, FULL_WORD, 1'b1, 16'd4);
        // full word followed by an empty last word
        push_word(32'h0000_0000, FULL_WORD, 1'b0, 16'd4);
        push_word(32'hFFFF_FFFF, 3'd0, 1'b1, 16'hFFFF);
        // byte counts above four clamp
        push_word(32'hA5A5_A5A5, 3'd7, 1'b1, 16'd4);
        push_word(32'h5A5A_5A5A, 3'd5, 1'b1, 16'hFFFF);
        // short word in the middle still mixes as a full word
        push_word(32'hCAFE_F00D, 3'd2, 1'b0, 16'd6);
        push_word(32'h1357_9BDF, FULL_WORD, 1'b1, 16'd0);
        push_word(32'h0000_0001, 3'd6, 1'b0, 16'd9);
        push_word(32'h8000_0000, 3'd1, 1'b1, 16'd0);
        push_word(32'hFFFF_FFFF, 3'd3, 1'b1, 16'h8000);
      end

      start = items_queued;
      while (items_queued - start < PHASE_ITEMS) random_message();
      // close any open message so each phase drains completely
      push_message($urandom_range(12), 16'($urandom_range(12)), 1'b0);

      while (word_queue.size() != 0 || in_valid || pending_hashes.size() != 0)
        @(negedge clk);
    end

    repeat (8) @(posedge clk);
    $display("Covered %0d words and %0d hashed messages over four flow-control phases,",
             words_accepted, hashes_checked);
    $display("including empty, tail, clamped-count and broken-framing messages.");
    if (errors == 0 && pending_hashes.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
rtl/sfh_pkg.sv
rtl/sfh_front.sv
rtl/sfh_queue.sv
rtl/sfh_back.sv
rtl/superfasthash_stream_top.sv
rtl/sfh_checker.sv
tb/superfasthash_stream_top_tb.sv
